>>> sv/bbe_pkg.sv
package bbe_pkg;

    localparam int VW      = 48;
    localparam int EXT_W   = VW - 1;
    localparam int TS_W    = 32;
    localparam int TS_FRAC = 16;
    localparam int LO_W    = VW / 2;
    localparam int HI_W    = VW - LO_W;
    localparam int PH_W    = HI_W + TS_W + 1;
    localparam int PL_W    = LO_W + TS_W;
    localparam int PW      = VW + TS_W + 1;

    localparam int IN_RAW  = 8 * VW;
    localparam int IN_W    = ((IN_RAW + 7) / 8) * 8;
    localparam int OUT_RAW = 5 * VW + 4;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

    typedef logic signed [VW-1:0] t_val;

    localparam t_val VMAX = t_val'({1'b0, {(VW-1){1'b1}}});
    localparam t_val VMIN = t_val'({1'b1, {(VW-1){1'b0}}});

    localparam logic [TS_W-1:0]  TS_RESET     = TS_W'(1092);
    localparam logic [EXT_W-1:0] HALF_RESET   = EXT_W'(65536);
    localparam logic [EXT_W-1:0] RADIUS_RESET = EXT_W'(6554);

    localparam logic [1:0] CFG_TIME_STEP = 2'd0;
    localparam logic [1:0] CFG_HALF      = 2'd1;
    localparam logic [1:0] CFG_RADIUS    = 2'd2;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_ACCEL = 2'd1,
        MODE_MOVE  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        BNC_NONE = 2'd0,
        BNC_LOW  = 2'd1,
        BNC_HIGH = 2'd2
    } t_bounce;

    typedef struct packed {
        logic start;
        logic scale;
        logic add;
    } t_lane_ctl;

    typedef struct packed {
        t_val    pos;
        t_val    vel;
        t_bounce bounce;
    } t_lane_res;

endpackage

>>> sv/bbe_lane.sv
module bbe_lane import bbe_pkg::*; (
    input  logic            i_clk,
    input  t_lane_ctl       i_ctl,
    input  t_mode           i_mode,
    input  logic            i_walls,
    input  t_val            i_accel,
    input  t_val            i_load_pos,
    input  t_val            i_load_vel,
    input  t_val            i_pos,
    input  t_val            i_vel,
    input  logic [TS_W-1:0] i_time_step,
    input  t_val            i_wall_low,
    input  t_val            i_wall_high,
    output t_lane_res       o_res
);

    function automatic logic signed [PW-1:0] ext(input t_val v);
        ext = {{(PW-VW){v[VW-1]}}, v};
    endfunction

    function automatic t_val sat_val(input logic signed [PW-1:0] v);
        logic [PW-VW:0] top;
        top = v[PW-1:VW-1];
        if (&top || ~|top) begin
            sat_val = v[VW-1:0];
        end else if (v[PW-1]) begin
            sat_val = VMIN;
        end else begin
            sat_val = VMAX;
        end
    endfunction

    t_mode                  r_mode;
    logic signed [PH_W-1:0] r_ph;
    logic [PL_W-1:0]        r_pl;
    t_val                   r_base;
    t_val                   r_pos;
    t_val                   r_vel;
    t_val                   r_load_pos;
    t_val                   r_load_vel;
    t_val                   r_scaled;
    t_val                   r_next;

    t_val                   op;
    logic signed [HI_W-1:0] op_hi;
    logic signed [TS_W:0]   ts_s;
    logic signed [PH_W-1:0] n_ph;
    logic [PL_W-1:0]        n_pl;
    logic signed [PW-1:0]   prod;
    logic signed [PW-1:0]   quo;
    t_val                   n_scaled;
    t_val                   n_next;
    t_val                   mir_lo;
    t_val                   mir_hi;
    t_val                   vel_abs;
    logic                   lo_hit;
    logic                   hi_hit;

    // stage 1: split multiply by the time step
    always_comb begin
        op    = (i_mode == MODE_ACCEL) ? i_accel : i_vel;
        op_hi = op[VW-1:LO_W];
        ts_s  = $signed({1'b0, i_time_step});
        n_ph  = op_hi * ts_s;
        n_pl  = op[LO_W-1:0] * i_time_step;
    end

    // stage 2: recombine, floor shift, saturate
    always_comb begin
        prod     = $signed({r_ph, {LO_W{1'b0}}}) + $signed({{(PW-PL_W){1'b0}}, r_pl});
        quo      = prod >>> TS_FRAC;
        n_scaled = sat_val(quo);
    end

    // stage 3: saturating add
    assign n_next = sat_val(ext(r_base) + ext(r_scaled));

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_mode     <= i_mode;
            r_ph       <= n_ph;
            r_pl       <= n_pl;
            r_base     <= (i_mode == MODE_ACCEL) ? i_vel : i_pos;
            r_pos      <= i_pos;
            r_vel      <= i_vel;
            r_load_pos <= i_load_pos;
            r_load_vel <= i_load_vel;
        end
        if (i_ctl.scale) begin
            r_scaled <= n_scaled;
        end
        if (i_ctl.add) begin
            r_next <= n_next;
        end
    end

    // stage 4: result select by mode; wall test and mirror on a move with walls on
    always_comb begin
        lo_hit  = (r_next <= i_wall_low);
        hi_hit  = (r_next >= i_wall_high);
        mir_lo  = sat_val((ext(i_wall_low) <<< 1) - ext(r_next));
        mir_hi  = sat_val((ext(i_wall_high) <<< 1) - ext(r_next));
        vel_abs = r_vel[VW-1] ? ((r_vel == VMIN) ? VMAX : -r_vel) : r_vel;

        o_res.pos    = r_pos;
        o_res.vel    = r_vel;
        o_res.bounce = BNC_NONE;
        case (r_mode)
            MODE_LOAD: begin
                o_res.pos = r_load_pos;
                o_res.vel = r_load_vel;
            end
            MODE_ACCEL: begin
                o_res.vel = r_next;
            end
            MODE_MOVE: begin
                if (i_walls) begin
                    if (lo_hit) begin
                        o_res.pos    = mir_lo;
                        o_res.vel    = vel_abs;
                        o_res.bounce = BNC_LOW;
                    end else if (hi_hit) begin
                        o_res.pos    = mir_hi;
                        o_res.vel    = -vel_abs;
                        o_res.bounce = BNC_HIGH;
                    end else begin
                        o_res.pos = r_next;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

>>> sv/bbe_merge.sv
module bbe_merge import bbe_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_commit,
    input  t_lane_res        i_res_x,
    input  t_lane_res        i_res_y,
    input  t_lane_res        i_res_z,
    output t_val             o_pos_x,
    output t_val             o_pos_y,
    output t_val             o_vel_x,
    output t_val             o_vel_y,
    output t_val             o_vel_z,
    output logic             o_free,
    output logic             o_tvalid,
    input  logic             i_tready,
    output logic [OUT_W-1:0] o_tdata
);

    t_val             r_pos_x;
    t_val             r_pos_y;
    t_val             r_vel_x;
    t_val             r_vel_y;
    t_val             r_vel_z;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    logic [OUT_W-1:0] n_out_data;

    always_comb begin
        n_out_data                    = '0;
        n_out_data[0*VW +: VW]        = i_res_x.pos;
        n_out_data[1*VW +: VW]        = i_res_y.pos;
        n_out_data[2*VW +: VW]        = i_res_x.vel;
        n_out_data[3*VW +: VW]        = i_res_y.vel;
        n_out_data[4*VW +: VW]        = i_res_z.vel;
        n_out_data[5*VW +: 2]         = i_res_x.bounce;
        n_out_data[5*VW + 2 +: 2]     = i_res_y.bounce;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_vel_x     <= '0;
            r_vel_y     <= '0;
            r_vel_z     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_commit) begin
                r_pos_x     <= i_res_x.pos;
                r_pos_y     <= i_res_y.pos;
                r_vel_x     <= i_res_x.vel;
                r_vel_y     <= i_res_y.vel;
                r_vel_z     <= i_res_z.vel;
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_commit) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_pos_x  = r_pos_x;
    assign o_pos_y  = r_pos_y;
    assign o_vel_x  = r_vel_x;
    assign o_vel_y  = r_vel_y;
    assign o_vel_z  = r_vel_z;
    assign o_free   = !r_out_valid || i_tready;
    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_commit |-> (!r_out_valid || i_tready))
        else $error("result overwritten before transaction");

    a_valid_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_commit))
        else $error("output valid without a committed step");

endmodule

>>> sv/bouncing_body_euler_step_top.sv
// One round body in a square box, stepped one transaction at a time.
// Input stream: tuser = mode (load / accelerate / move), tdata = the three
// accelerations and the five load values. Output stream: one transaction per
// input transaction with the state after the step and the wall-hit codes.
// Config port: i_cfg_we/i_cfg_idx/i_cfg_data write time step, half extent,
// radius; write only while no step is in flight.
// Three lanes (x, y, z) each multiply, scale and add on one axis, and the x and y
// lanes also wall-test; a merge stage holds the body state and the output register.
// Path: input buffer, lane states IDLE, SCALE, ADD, WALL, then output register.
// Transactions go one at a time through the state loop of a lane (multiply,
// scale, add, wall test/commit); the next transaction is taken into an input
// buffer while one is in flight.
// Reset: state zero, registers at their defaults, both streams idle.
// A stalled output holds the result; the lanes then wait in the wall stage
// and the input buffer fills and drops tready.
module bouncing_body_euler_step_top import bbe_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // accel_x, accel_y, accel_z, load_pos_x,
                                             // load_pos_y, load_vel_x, load_vel_y, load_vel_z
    input  logic [1:0]       s_axis_tuser,   // mode
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // pos_x, pos_y, vel_x, vel_y, vel_z,
                                             // bounce_x, bounce_y, zero pad
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [EXT_W-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCALE = 4'b0010,
        ST_ADD   = 4'b0100,
        ST_WALL  = 4'b1000
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic             r_in_valid;
    logic [IN_W-1:0]  r_in_data;
    logic [1:0]       r_in_user;
    logic [TS_W-1:0]  r_ts;
    logic [EXT_W-1:0] r_half;
    logic [EXT_W-1:0] r_rad;

    t_lane_ctl ctl;
    logic      commit;
    logic      out_free;
    t_mode     mode;
    t_val      wall_low;
    t_val      wall_high;
    t_val      pos_x, pos_y, vel_x, vel_y, vel_z;
    t_lane_res res_x, res_y, res_z;

    assign s_axis_tready = !r_in_valid;
    assign mode          = t_mode'(r_in_user);
    assign wall_low      = $signed({1'b0, r_rad}) - $signed({1'b0, r_half});
    assign wall_high     = $signed({1'b0, r_half}) - $signed({1'b0, r_rad});

    always_comb begin
        n_state   = r_state;
        ctl.start = 1'b0;
        ctl.scale = 1'b0;
        ctl.add   = 1'b0;
        commit    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (r_in_valid) begin
                    ctl.start = 1'b1;
                    n_state   = ST_SCALE;
                end
            end
            ST_SCALE: begin
                ctl.scale = 1'b1;
                n_state   = ST_ADD;
            end
            ST_ADD: begin
                ctl.add = 1'b1;
                n_state = ST_WALL;
            end
            ST_WALL: begin
                if (out_free) begin
                    commit  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_in_valid <= 1'b0;
            r_ts       <= TS_RESET;
            r_half     <= HALF_RESET;
            r_rad      <= RADIUS_RESET;
        end else begin
            r_state <= n_state;
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (ctl.start) begin
                r_in_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TIME_STEP: r_ts   <= i_cfg_data[TS_W-1:0];
                    CFG_HALF:      r_half <= i_cfg_data;
                    CFG_RADIUS:    r_rad  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata;
            r_in_user <= s_axis_tuser;
        end
    end

    bbe_lane u_lane_x (
        .i_clk       (i_clk),
        .i_ctl       (ctl),
        .i_mode      (mode),
        .i_walls     (1'b1),
        .i_accel     (r_in_data[0*VW +: VW]),
        .i_load_pos  (r_in_data[3*VW +: VW]),
        .i_load_vel  (r_in_data[5*VW +: VW]),
        .i_pos       (pos_x),
        .i_vel       (vel_x),
        .i_time_step (r_ts),
        .i_wall_low  (wall_low),
        .i_wall_high (wall_high),
        .o_res       (res_x)
    );

    bbe_lane u_lane_y (
        .i_clk       (i_clk),
        .i_ctl       (ctl),
        .i_mode      (mode),
        .i_walls     (1'b1),
        .i_accel     (r_in_data[1*VW +: VW]),
        .i_load_pos  (r_in_data[4*VW +: VW]),
        .i_load_vel  (r_in_data[6*VW +: VW]),
        .i_pos       (pos_y),
        .i_vel       (vel_y),
        .i_time_step (r_ts),
        .i_wall_low  (wall_low),
        .i_wall_high (wall_high),
        .o_res       (res_y)
    );

    bbe_lane u_lane_z (
        .i_clk       (i_clk),
        .i_ctl       (ctl),
        .i_mode      (mode),
        .i_walls     (1'b0),
        .i_accel     (r_in_data[2*VW +: VW]),
        .i_load_pos  ('0),
        .i_load_vel  (r_in_data[7*VW +: VW]),
        .i_pos       ('0),
        .i_vel       (vel_z),
        .i_time_step (r_ts),
        .i_wall_low  (wall_low),
        .i_wall_high (wall_high),
        .o_res       (res_z)
    );

    bbe_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (commit),
        .i_res_x  (res_x),
        .i_res_y  (res_y),
        .i_res_z  (res_z),
        .o_pos_x  (pos_x),
        .o_pos_y  (pos_y),
        .o_vel_x  (vel_x),
        .o_vel_y  (vel_y),
        .o_vel_z  (vel_z),
        .o_free   (out_free),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata)
    );

    a_lane_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.start |=> (r_state == ST_SCALE) ##1 (r_state == ST_ADD)
                      ##1 (r_state == ST_WALL))
        else $error("lane stages out of sequence");

    a_buffer_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_state != ST_IDLE) |=> r_in_valid)
        else $error("buffered transaction lost while a step is in flight");

endmodule

>>> tb/bouncing_body_euler_step_top_test.sv
module bouncing_body_euler_step_top_test;
    import bbe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          PHASES      = 9;
    localparam int          PHASE_ITEMS = 100;
    localparam logic [1:0]  CFG_SPARE   = 2'd3;
    localparam t_val        ONE_M       = 48'sd65536;

    typedef logic signed [2*VW-1:0] t_wide;

    typedef struct packed {
        t_mode mode;
        t_val  acc_x;
        t_val  acc_y;
        t_val  acc_z;
        t_val  ld_px;
        t_val  ld_py;
        t_val  ld_vx;
        t_val  ld_vy;
        t_val  ld_vz;
    } t_step_in;

    typedef struct packed {
        t_val    px;
        t_val    py;
        t_val    vx;
        t_val    vy;
        t_val    vz;
        t_bounce bx;
        t_bounce by;
    } t_body_out;

    typedef enum logic {ROW_CFG, ROW_STEP} t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [1:0]       cfg_idx;
        logic [EXT_W-1:0] cfg_data;
        t_step_in         item;
        logic             has_exp;
        t_body_out        exp;
    } t_row;

    typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_PERIODIC, RX_BURSTY} t_rx_style;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;    // accel_x, accel_y, accel_z, load_pos_x,
                                       // load_pos_y, load_vel_x, load_vel_y, load_vel_z
    logic [1:0]       s_axis_tuser;    // mode
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;    // pos_x, pos_y, vel_x, vel_y, vel_z,
                                       // bounce_x, bounce_y, zero pad
    logic             i_cfg_we;
    logic [1:0]       i_cfg_idx;
    logic [EXT_W-1:0] i_cfg_data;

    t_val             body_px, body_py, body_vx, body_vy, body_vz;
    logic [TS_W-1:0]  cfg_dt;
    logic [EXT_W-1:0] cfg_half, cfg_rad;

    t_body_out        pending_states[$];
    t_row             dir_tbl[$];
    int               bad_count = 0;
    int unsigned      cycle_count = 0;

    t_rx_style        rx_style = RX_FREE;
    int               rx_tick = 0;
    int               rx_hold = 0;
    bit               tx_gappy = 1'b0;
    int               tx_burst = 0;

    t_body_out        mon_want, mon_got;
    logic [VW-1:0]    mon_wf[7], mon_gf[7];
    string            fld_names[7] = '{"pos_x", "pos_y", "vel_x", "vel_y", "vel_z",
                                       "bounce_x", "bounce_y"};

    bouncing_body_euler_step_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------- body predictor ----------------

    function automatic t_val clamp(t_wide x);
        t_wide w_max, w_min;
        w_max = VMAX;
        w_min = VMIN;
        if (x > w_max) return VMAX;
        if (x < w_min) return VMIN;
        return t_val'(x);
    endfunction

    function automatic t_val sat_sum(t_val a, t_val b);
        t_wide wa, wb;
        wa = a;
        wb = b;
        return clamp(wa + wb);
    endfunction

    // floor(v * dt / 2^16), saturated
    function automatic t_val scale_by_dt(t_val v);
        t_wide wv, wd, prod;
        wv = v;
        wd = {{(2*VW-TS_W){1'b0}}, cfg_dt};
        prod = wv * wd;
        return clamp(prod >>> TS_FRAC);
    endfunction

    function automatic t_val abs_clamp(t_val v);
        if (v >= 0) return v;
        if (v == VMIN) return VMAX;
        return -v;
    endfunction

    function automatic void bounce_axis(inout t_val p, inout t_val v, output t_bounce code);
        t_wide nxt, lo, hi, wr, wh;
        nxt = sat_sum(p, scale_by_dt(v));
        wr = {{(2*VW-EXT_W){1'b0}}, cfg_rad};
        wh = {{(2*VW-EXT_W){1'b0}}, cfg_half};
        lo = wr - wh;
        hi = wh - wr;
        if (nxt <= lo) begin
            p = clamp(lo + lo - nxt);
            v = abs_clamp(v);
            code = BNC_LOW;
        end else if (nxt >= hi) begin
            p = clamp(hi + hi - nxt);
            v = -abs_clamp(v);
            code = BNC_HIGH;
        end else begin
            p = clamp(nxt);
            code = BNC_NONE;
        end
    endfunction

    function automatic t_body_out step_body(t_step_in it);
        t_body_out r;
        t_bounce   bx, by;
        bx = BNC_NONE;
        by = BNC_NONE;
        case (it.mode)
            MODE_LOAD: begin
                body_px = it.ld_px;
                body_py = it.ld_py;
                body_vx = it.ld_vx;
                body_vy = it.ld_vy;
                body_vz = it.ld_vz;
            end
            MODE_ACCEL: begin
                body_vx = sat_sum(body_vx, scale_by_dt(it.acc_x));
                body_vy = sat_sum(body_vy, scale_by_dt(it.acc_y));
                body_vz = sat_sum(body_vz, scale_by_dt(it.acc_z));
            end
            MODE_MOVE: begin
                bounce_axis(body_py, body_vy, by);
                bounce_axis(body_px, body_vx, bx);
            end
            default: ;
        endcase
        r = '{body_px, body_py, body_vx, body_vy, body_vz, bx, by};
        return r;
    endfunction

    function automatic void apply_cfg(logic [1:0] idx, logic [EXT_W-1:0] data);
        case (idx)
            CFG_TIME_STEP: cfg_dt = data[TS_W-1:0];
            CFG_HALF:      cfg_half = data;
            CFG_RADIUS:    cfg_rad = data;
            default: ;
        endcase
    endfunction

    function automatic void body_fields(input t_body_out b, output logic [VW-1:0] f[7]);
        f[0] = b.px;
        f[1] = b.py;
        f[2] = b.vx;
        f[3] = b.vy;
        f[4] = b.vz;
        f[5] = VW'(b.bx);
        f[6] = VW'(b.by);
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic t_val rnd_val();
        return t_val'({$urandom, $urandom});
    endfunction

    // mostly inside the box, sometimes the extremes or any bit pattern
    function automatic t_val rnd_scaled();
        logic [63:0] span, r;
        case ($urandom_range(0, 9))
            0: return VMAX;
            1: return VMIN;
            2, 3: return rnd_val();
            default: begin
                span = (cfg_half == '0) ? 64'd65536 : 64'(cfg_half) + 64'(cfg_rad);
                r = {$urandom, $urandom} % (2 * span + 1);
                return t_val'(r - span);
            end
        endcase
    endfunction

    function automatic t_step_in rnd_payload(t_mode m);
        t_step_in it;
        it = '{m, rnd_val(), rnd_val(), rnd_val(), rnd_val(), rnd_val(),
               rnd_val(), rnd_val(), rnd_val()};
        return it;
    endfunction

    function automatic t_step_in rand_item();
        t_step_in it;
        int       pick;
        pick = $urandom_range(0, 9);
        it = '{MODE_MOVE, rnd_scaled(), rnd_scaled(), rnd_scaled(), rnd_scaled(),
               rnd_scaled(), rnd_scaled(), rnd_scaled(), rnd_scaled()};
        if (pick == 0) it.mode = MODE_LOAD;
        else if (pick <= 3) it.mode = MODE_ACCEL;
        else if (pick == 9) it.mode = MODE_NONE;
        return it;
    endfunction

    function automatic t_row cfg_row(logic [1:0] idx, logic [EXT_W-1:0] data);
        t_row r;
        r = '0;
        r.kind = ROW_CFG;
        r.cfg_idx = idx;
        r.cfg_data = data;
        return r;
    endfunction

    function automatic t_row step_row(t_mode m);
        t_row r;
        r = '0;
        r.kind = ROW_STEP;
        r.item = rnd_payload(m);
        return r;
    endfunction

    function automatic t_row zero_row(t_mode m);
        t_row r;
        r = step_row(m);
        r.has_exp = 1'b1;
        r.exp = '{'0, '0, '0, '0, '0, BNC_NONE, BNC_NONE};
        return r;
    endfunction

    function automatic t_row accel_row(t_val ax, t_val ay, t_val az);
        t_row r;
        r = step_row(MODE_ACCEL);
        r.item.acc_x = ax;
        r.item.acc_y = ay;
        r.item.acc_z = az;
        return r;
    endfunction

    function automatic t_row load_row(t_val px, t_val py, t_val vx, t_val vy, t_val vz);
        t_row r;
        r = step_row(MODE_LOAD);
        r.item.ld_px = px;
        r.item.ld_py = py;
        r.item.ld_vx = vx;
        r.item.ld_vy = vy;
        r.item.ld_vz = vz;
        r.has_exp = 1'b1;
        r.exp = '{px, py, vx, vy, vz, BNC_NONE, BNC_NONE};
        return r;
    endfunction

    function automatic void add_row(t_row r);
        dir_tbl = {dir_tbl, r};
    endfunction

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic push_step(t_step_in it, logic has_exp, t_body_out exp);
        t_body_out pred;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.mode;
        s_axis_tdata  <= {it.ld_vz, it.ld_vy, it.ld_vx, it.ld_py, it.ld_px,
                          it.acc_z, it.acc_y, it.acc_x};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pred = step_body(it);
        pending_states = {pending_states, (has_exp ? exp : pred)};
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_states.size() != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [EXT_W-1:0] data);
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        i_cfg_we   <= 1'b1;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
        apply_cfg(idx, data);
    endtask

    task automatic tx_idle();
        if (tx_gappy) begin
            if (tx_burst == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                tx_burst = $urandom_range(1, 20);
            end else begin
                tx_burst--;
            end
        end
    endtask

    // ---------------- receiver stall pattern ----------------

    always @(negedge i_clk) begin
        rx_tick++;
        case (rx_style)
            RX_FREE:     m_axis_tready <= 1'b1;
            RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: m_axis_tready <= (rx_tick % 8) >= 3;
            default: begin
                if (rx_hold > 0) begin
                    rx_hold--;
                    m_axis_tready <= 1'b0;
                end else if ($urandom_range(0, 15) == 0) begin
                    rx_hold = $urandom_range(5, 20);
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        endcase
    end

    // ---------------- result checker ----------------

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_states.size() == 0) begin
                $display("%0t: unexpected result transaction, tdata %h", $time, m_axis_tdata);
                bad_count++;
            end else begin
                mon_want = pending_states.pop_front();
                mon_got.px = m_axis_tdata[0*VW +: VW];
                mon_got.py = m_axis_tdata[1*VW +: VW];
                mon_got.vx = m_axis_tdata[2*VW +: VW];
                mon_got.vy = m_axis_tdata[3*VW +: VW];
                mon_got.vz = m_axis_tdata[4*VW +: VW];
                mon_got.bx = t_bounce'(m_axis_tdata[5*VW +: 2]);
                mon_got.by = t_bounce'(m_axis_tdata[5*VW+2 +: 2]);
                body_fields(mon_want, mon_wf);
                body_fields(mon_got, mon_gf);
                for (int k = 0; k < 7; k++) begin
                    if (mon_wf[k] !== mon_gf[k]) begin
                        $display("%0t: %s expected %h actual %h", $time, fld_names[k],
                                 mon_wf[k], mon_gf[k]);
                        bad_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("bouncing_body_euler_step_top: mismatch");
            $finish;
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        t_step_in         it;
        logic [TS_W-1:0]  ts_pick;
        logic [EXT_W-1:0] half_pick, rad_pick;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_LOAD;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_TIME_STEP;
        i_cfg_data    = '0;

        body_px = '0;
        body_py = '0;
        body_vx = '0;
        body_vy = '0;
        body_vz = '0;
        cfg_dt   = TS_RESET;
        cfg_half = HALF_RESET;
        cfg_rad  = RADIUS_RESET;

        add_row(zero_row(MODE_NONE));
        add_row(zero_row(MODE_MOVE));
        add_row(accel_row(VMAX, VMAX, VMAX));
        add_row(accel_row(VMIN, VMIN, VMIN));
        add_row(load_row(VMAX, VMIN, VMIN, VMAX, VMIN));
        add_row(step_row(MODE_NONE));
        add_row(step_row(MODE_MOVE));
        add_row(load_row('0, '0, 10 * ONE_M, -10 * ONE_M, 3 * ONE_M));
        add_row(step_row(MODE_MOVE));
        add_row(step_row(MODE_MOVE));
        // full-width data: only the low 32 bits reach the time step
        add_row(cfg_row(CFG_TIME_STEP, '1));
        add_row(cfg_row(CFG_SPARE, '1));
        add_row(accel_row(VMAX, VMIN, ONE_M));
        add_row(step_row(MODE_MOVE));
        add_row(cfg_row(CFG_TIME_STEP, '0));
        add_row(step_row(MODE_ACCEL));
        add_row(step_row(MODE_MOVE));
        add_row(cfg_row(CFG_HALF, '1));
        add_row(cfg_row(CFG_RADIUS, '0));
        add_row(cfg_row(CFG_TIME_STEP, EXT_W'(65536)));
        add_row(load_row('0, '0, VMAX, VMIN, '0));
        add_row(step_row(MODE_MOVE));
        // radius larger than half extent: low wall test wins
        add_row(cfg_row(CFG_HALF, EXT_W'(65536)));
        add_row(cfg_row(CFG_RADIUS, EXT_W'(131072)));
        add_row(load_row('0, '0, '0, '0, '0));
        add_row(step_row(MODE_MOVE));
        // mirror lands beyond the opposite wall and stays there
        add_row(cfg_row(CFG_RADIUS, '0));
        add_row(load_row(t_val'(-60000), t_val'(60000), -5 * ONE_M, 5 * ONE_M, '0));
        add_row(step_row(MODE_MOVE));
        // mirror saturation and magnitude of the most negative velocity
        add_row(cfg_row(CFG_HALF, '0));
        add_row(cfg_row(CFG_RADIUS, '1));
        add_row(load_row('0, '0, VMIN, VMIN, '0));
        add_row(step_row(MODE_MOVE));
        add_row(cfg_row(CFG_RADIUS, 47'h4000_0000_0000));
        add_row(load_row(VMAX, VMAX, '0, '0, '0));
        add_row(step_row(MODE_MOVE));

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tbl[n]) begin
            if (dir_tbl[n].kind == ROW_CFG) begin
                drain();
                cfg_write(dir_tbl[n].cfg_idx, dir_tbl[n].cfg_data);
            end else begin
                push_step(dir_tbl[n].item, dir_tbl[n].has_exp, dir_tbl[n].exp);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            if (ph == 0) begin
                cfg_write(CFG_TIME_STEP, EXT_W'(TS_RESET));
                cfg_write(CFG_HALF, HALF_RESET);
                cfg_write(CFG_RADIUS, RADIUS_RESET);
                rx_style = RX_FREE;
                tx_gappy = 1'b0;
            end else begin
                case ($urandom_range(0, 5))
                    0: ts_pick = '0;
                    1: ts_pick = '1;
                    2: ts_pick = TS_RESET;
                    3: ts_pick = TS_W'(65536);
                    default: ts_pick = TS_W'($urandom_range(1, 1 << 18));
                endcase
                case ($urandom_range(0, 5))
                    0: half_pick = '0;
                    1: half_pick = '1;
                    2: half_pick = HALF_RESET;
                    default: half_pick = EXT_W'({$urandom, $urandom} >> $urandom_range(17, 60));
                endcase
                case ($urandom_range(0, 5))
                    0: rad_pick = '0;
                    1: rad_pick = half_pick + EXT_W'($urandom_range(1, 65536));
                    2: rad_pick = '1;
                    default: rad_pick = half_pick >> $urandom_range(1, 6);
                endcase
                cfg_write(CFG_TIME_STEP, {15'($urandom), ts_pick});
                cfg_write(CFG_HALF, half_pick);
                cfg_write(CFG_RADIUS, rad_pick);
                if ($urandom_range(0, 2) == 0) cfg_write(CFG_SPARE, EXT_W'({$urandom, $urandom}));
                rx_style = t_rx_style'($urandom_range(0, 3));
                tx_gappy = ($urandom_range(0, 3) != 0);
            end
            tx_burst = $urandom_range(1, 20);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                it = rand_item();
                push_step(it, 1'b0, '0);
                if (i == PHASE_ITEMS / 2) drain();
                else tx_idle();
            end
        end

        drain();
        repeat (12) @(negedge i_clk);
        if (bad_count == 0) begin
            $display("bouncing_body_euler_step_top: match");
        end else begin
            $display("bouncing_body_euler_step_top: mismatch");
        end
        $finish;
    end

endmodule

>>> files.f
sv/bbe_pkg.sv
sv/bbe_lane.sv
sv/bbe_merge.sv
sv/bouncing_body_euler_step_top.sv
tb/bouncing_body_euler_step_top_test.sv
